// ===== design/smbus_host_register_block_top_macros.svh =====
// ----------------------------------------------------------------------------
// SMBus host register block: assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SMBUS_HOST_REGISTER_BLOCK_TOP_MACROS_SVH
`define SMBUS_HOST_REGISTER_BLOCK_TOP_MACROS_SVH

// Assert a property on an explicit clock and active-low reset
`define SMBHRB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset
`define SMBHRB_ASSERT(label, prop, msg) \
  `SMBHRB_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/smbhrb_pkg.sv =====
// ----------------------------------------------------------------------------
// SMBus host register block package
// Word types, request codes, register indexes and status codes.
// ----------------------------------------------------------------------------
package smbhrb_pkg;

  // Request codes carried by req_type
  typedef enum logic [2:0] {
    REQ_WR_INDEX = 3'd0,
    REQ_RD_INDEX = 3'd1,
    REQ_WR_DATA  = 3'd2,
    REQ_RD_DATA  = 3'd3,
    REQ_TICK     = 3'd4
  } req_e;

  // Register indexes behind the index port
  localparam logic [7:0] IDX_STATUS_LO  = 8'h00;
  localparam logic [7:0] IDX_STATUS_HI  = 8'h01;
  localparam logic [7:0] IDX_CONTROL_LO = 8'h02;
  localparam logic [7:0] IDX_CONTROL_HI = 8'h03;
  localparam logic [7:0] IDX_ADDR       = 8'h04;
  localparam logic [7:0] IDX_CMD        = 8'h05;
  localparam logic [7:0] IDX_BLK_PTR    = 8'h06;
  localparam logic [7:0] IDX_COUNT      = 8'h07;
  localparam logic [7:0] IDX_DATA_FIRST = 8'h08;
  localparam logic [7:0] IDX_DATA_LAST  = 8'h0f;
  localparam logic [7:0] IDX_AUX0       = 8'h10;
  localparam logic [7:0] IDX_AUX1       = 8'h11;
  localparam logic [7:0] IDX_AUX2       = 8'h12;
  localparam logic [7:0] IDX_AUX3       = 8'h13;
  localparam logic [7:0] IDX_AUX4       = 8'hff;

  // Status codes
  localparam logic [7:0] ST_KILLED    = 8'h80;
  localparam logic [7:0] ST_DONE      = 8'h40;
  localparam logic [7:0] ST_NO_ACK    = 8'h20;
  localparam logic [7:0] ST_DEV_ERR   = 8'h10;
  localparam logic [7:0] ST_HOST_BUSY = 8'h08;
  localparam logic [7:0] ST_ALIAS     = 8'h04;
  localparam logic [7:0] ST_CLR_LO    = 8'hf0;
  localparam logic [7:0] ST_CLR_HI    = 8'h07;

  // Control low byte bits
  localparam int unsigned CTL_KILL_BIT  = 5;
  localparam int unsigned CTL_START_BIT = 4;

  // Protocol codes, control bits 3..1
  localparam logic [2:0] PROTO_QUICK     = 3'd0;
  localparam logic [2:0] PROTO_BYTE      = 3'd1;
  localparam logic [2:0] PROTO_BYTE_DATA = 3'd2;
  localparam logic [2:0] PROTO_WORD      = 3'd3;
  localparam logic [2:0] PROTO_BLOCK     = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wdata;
    logic       dev_ack;
    logic [7:0] dev_byte0;
    logic [7:0] dev_byte1;
  } in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_out;
    logic       xfer_valid;
    logic [6:0] xfer_addr;
    logic       xfer_read;
    logic [2:0] xfer_protocol;
    logic [7:0] xfer_cmd;
    logic [7:0] xfer_data0;
    logic [7:0] xfer_data1;
    logic       busy_res;
  } out_t;

endpackage

// ===== design/smbus_host_register_block_top.sv =====
// ----------------------------------------------------------------------------
// SMBus host register block
// Index/data register model of an SMBus host controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one word per
//   request: index write or read, data write or read, or a bit-time tick.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result word per request, in order.
//   cfg_we_i/cfg_wdata_i write the interrupt enable bit; write it only while idle.
// Timing:
//   A word is registered in the input register on acceptance and its result
//   is then registered in the result register, which drives out_valid_o.
//   Throughput is one word per cycle while out_ready_i is high, set by the
//   single decode/update step between the input and result registers.
// Reset:
//   Valid flags and state registers clear, the block pointer reads 1, both channels empty.
// Stall:
//   While out_ready_i is low the result holds; one more word is still
//   taken into the input register, then in_ready_o drops.
// Data indexes 8..15 map onto store offsets 0..7; data reads return zero unless the block pointer is 0.
// ----------------------------------------------------------------------------
module smbus_host_register_block_top
  import smbhrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  // Pipeline registers
  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  logic advance;

  // Architectural state
  logic       irq_en_q;
  logic [7:0] index_q,   index_d;
  logic [7:0] status_q,  status_d;
  logic [7:0] ctrl_lo_q, ctrl_lo_d;
  logic [7:0] ctrl_hi_q, ctrl_hi_d;
  logic [7:0] taddr_q,   taddr_d;
  logic [7:0] cmd_q,     cmd_d;
  logic [1:0] bp_q,      bp_d;
  logic [7:0] store_q [8];
  logic [7:0] store_d [8];
  logic [7:0] aux_q [3];
  logic [7:0] aux_d [3];
  logic [7:1] aux3_q,    aux3_d;
  logic [7:0] pend_q,    pend_d;
  logic [5:0] delay_q,   delay_d;
  logic       irq_q,     irq_d;

  out_t       res;
  logic [2:0] nbytes;
  logic [2:0] proto;
  logic [1:0] bp_inc;
  logic [2:0] slot;
  logic       is_data_idx;

  // Handshake: input register moves forward when the result slot frees
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign proto       = in_q.wdata[3:1];
  assign bp_inc      = bp_q + 2'd1;
  assign slot        = index_q[2:0];
  assign is_data_idx = index_q inside {[IDX_DATA_FIRST:IDX_DATA_LAST]};

  // Decode the held word and compute next state and result
  always_comb begin
    index_d   = index_q;
    status_d  = status_q;
    ctrl_lo_d = ctrl_lo_q;
    ctrl_hi_d = ctrl_hi_q;
    taddr_d   = taddr_q;
    cmd_d     = cmd_q;
    bp_d      = bp_q;
    store_d   = store_q;
    aux_d     = aux_q;
    aux3_d    = aux3_q;
    pend_d    = pend_q;
    delay_d   = delay_q;
    irq_d     = irq_q;
    res       = '0;
    nbytes    = '0;

    if (advance) begin
      case (req_e'(in_q.req_type))
        REQ_WR_INDEX: index_d = in_q.wdata;
        REQ_RD_INDEX: res.rdata = index_q;
        REQ_WR_DATA: begin
          // every data write drops the pending status first
          pend_d = '0;
          case (index_q)
            IDX_STATUS_LO: begin
              status_d = status_q & ~(in_q.wdata & ST_CLR_LO);
              if (status_d == ST_ALIAS) begin
                status_d = '0;
              end
            end
            IDX_STATUS_HI: status_d = status_q & ~(in_q.wdata & ST_CLR_HI);
            IDX_CONTROL_LO: begin
              ctrl_lo_d = in_q.wdata;
              if (in_q.wdata[CTL_KILL_BIT]) begin
                // kill a pending command
                if (pend_q != '0) begin
                  delay_d  = '0;
                  status_d = ST_KILLED;
                end
              end else if (in_q.wdata[CTL_START_BIT]) begin
                // start a transfer: drive the address phase
                nbytes            = 3'd1;
                res.xfer_valid    = 1'b1;
                res.xfer_addr     = taddr_q[7:1];
                res.xfer_read     = taddr_q[0];
                res.xfer_protocol = proto;
                if (!in_q.dev_ack) begin
                  pend_d = ST_NO_ACK;
                end else begin
                  pend_d = ST_DONE;
                  bp_d   = 2'd1;
                  case (proto)
                    PROTO_QUICK: begin
                      nbytes = 3'd1;
                    end
                    PROTO_BYTE: begin
                      if (taddr_q[0]) begin
                        store_d[0] = in_q.dev_byte0;
                      end else begin
                        res.xfer_data0 = store_q[0];
                      end
                      nbytes = 3'd2;
                    end
                    PROTO_BYTE_DATA: begin
                      res.xfer_cmd = cmd_q;
                      if (taddr_q[0]) begin
                        store_d[0] = in_q.dev_byte0;
                      end else begin
                        res.xfer_data0 = store_q[0];
                      end
                      nbytes = 3'd3;
                    end
                    PROTO_WORD: begin
                      res.xfer_cmd = cmd_q;
                      if (taddr_q[0]) begin
                        store_d[0] = in_q.dev_byte0;
                        store_d[1] = in_q.dev_byte1;
                      end else begin
                        res.xfer_data0 = store_q[0];
                        res.xfer_data1 = store_q[1];
                      end
                      nbytes = 3'd4;
                    end
                    default: begin
                      // block and unknown protocols report a device error
                      bp_d   = (proto == PROTO_BLOCK) ? 2'd0 : 2'd1;
                      pend_d = ST_DEV_ERR;
                      nbytes = 3'd0;
                    end
                  endcase
                end
              end
            end
            IDX_CONTROL_HI: ctrl_hi_d = in_q.wdata;
            IDX_ADDR:       taddr_d   = in_q.wdata;
            IDX_CMD:        cmd_d     = in_q.wdata;
            IDX_AUX0:       aux_d[0]  = in_q.wdata;
            IDX_AUX1:       aux_d[1]  = in_q.wdata;
            IDX_AUX2:       aux_d[2]  = in_q.wdata;
            IDX_AUX3:       aux3_d    = in_q.wdata[7:1];
            default: begin
              if (is_data_idx) begin
                store_d[slot] = in_q.wdata;
              end
            end
          endcase
          // load busy status and the bit-time countdown, 1 + 9 x bytes
          if (pend_d != '0) begin
            status_d = ST_HOST_BUSY;
            delay_d  = {nbytes, 3'b000} + {3'b000, nbytes} + 6'd1;
          end
        end
        REQ_RD_DATA: begin
          case (index_q)
            IDX_STATUS_LO:  res.rdata = status_q;
            IDX_CONTROL_LO: res.rdata = ctrl_lo_q;
            IDX_CONTROL_HI: res.rdata = ctrl_hi_q;
            IDX_ADDR:       res.rdata = taddr_q;
            IDX_CMD:        res.rdata = cmd_q;
            IDX_BLK_PTR:    res.rdata = {6'b0, bp_q};
            IDX_AUX0:       res.rdata = aux_q[0];
            IDX_AUX1:       res.rdata = aux_q[1];
            IDX_AUX2:       res.rdata = aux_q[2];
            IDX_AUX3:       res.rdata = {aux3_q, 1'b0};
            default: begin
              // status high, count and aux 4 read as zero
              if (is_data_idx) begin
                res.rdata = (bp_q == 2'd0) ? store_q[slot] : 8'h00;
                if (index_q == IDX_DATA_LAST) begin
                  bp_d = bp_inc;
                  if (irq_en_q) begin
                    irq_d = (bp_inc != 2'd0);
                  end
                end
              end
            end
          endcase
        end
        REQ_TICK: begin
          // count down and post the pending status at zero
          if (delay_q != '0) begin
            delay_d = delay_q - 6'd1;
            if (delay_q == 6'd1) begin
              status_d = pend_q;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // dropping the interrupt enable clears the interrupt level
    if (cfg_we_i && !cfg_wdata_i && irq_en_q) begin
      irq_d = 1'b0;
    end

    res.irq_out  = irq_d;
    res.busy_res = (delay_d != '0);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // Register file state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q  <= 1'b0;
      index_q   <= '0;
      status_q  <= '0;
      ctrl_lo_q <= '0;
      ctrl_hi_q <= '0;
      taddr_q   <= '0;
      cmd_q     <= '0;
      bp_q      <= 2'd1;
      store_q   <= '{default: '0};
      aux_q     <= '{default: '0};
      aux3_q    <= '0;
      pend_q    <= '0;
      delay_q   <= '0;
      irq_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        irq_en_q <= cfg_wdata_i;
      end
      index_q   <= index_d;
      status_q  <= status_d;
      ctrl_lo_q <= ctrl_lo_d;
      ctrl_hi_q <= ctrl_hi_d;
      taddr_q   <= taddr_d;
      cmd_q     <= cmd_d;
      bp_q      <= bp_d;
      store_q   <= store_d;
      aux_q     <= aux_d;
      aux3_q    <= aux3_d;
      pend_q    <= pend_d;
      delay_q   <= delay_d;
      irq_q     <= irq_d;
    end
  end

endmodule

// ===== design/smbhrb_checker.sv =====
// ----------------------------------------------------------------------------
// SMBus host register block checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "smbus_host_register_block_top_macros.svh"

module smbhrb_checker
  import smbhrb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // Hold a stalled result word
  `SMBHRB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // Take input whenever the result slot is empty
  `SMBHRB_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty result slot")

  // Drop transfer fields when no transfer started
  `SMBHRB_ASSERT(a_xfer_fields_zero, out_valid_o && !out_data_o.xfer_valid |-> out_data_o.xfer_addr == 7'd0 && !out_data_o.xfer_read && out_data_o.xfer_protocol == 3'd0 && out_data_o.xfer_cmd == 8'd0 && out_data_o.xfer_data0 == 8'd0 && out_data_o.xfer_data1 == 8'd0, "transfer fields set without a transfer")

  // A started transfer always loads the countdown
  `SMBHRB_ASSERT(a_xfer_busy, out_valid_o && out_data_o.xfer_valid |-> out_data_o.busy_res, "transfer started without countdown")

  // Second data byte only on word writes
  `SMBHRB_ASSERT(a_data1_word_write, out_valid_o && out_data_o.xfer_data1 != 8'd0 |-> out_data_o.xfer_protocol == PROTO_WORD && !out_data_o.xfer_read, "second byte outside word write")

endmodule

bind smbus_host_register_block_top smbhrb_checker u_smbhrb_checker (.*);
